// File: src/dfcc_pkg.sv
// Shared types, constants and plane-forming function for the draw frustum-cull classifier.
// Depends on nothing; every other file in src refers to it by scoped names.

package dfcc_pkg;

	localparam int COORD_W    = 32;               // Q16.16 box coordinate
	localparam int FRAC_W     = 16;               // fractional bits of Q16.16
	localparam int COEF_W     = COORD_W + 1;      // Q17.16 plane coefficient
	localparam int PROD_W     = COEF_W + COORD_W; // exact coefficient * coordinate
	localparam int SUM_W      = PROD_W + 3;       // three products plus the offset term
	localparam int AXES       = 3;
	localparam int W_IDX      = 3;                // plane offset sits after x, y, z
	localparam int NUM_PLANES = 6;
	localparam int MAT_REGS   = 8;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 64;
	localparam int OUT_CNT_W  = 16;

	typedef logic [MAT_REGS-1:0][CFG_DATA_W-1:0] mat_t;
	typedef logic [W_IDX:0][COEF_W-1:0] plane_t;

	// Identity matrix, one 1.0 in Q16.16 per row
	localparam mat_t MAT_RESET = {
		64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
		64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000
	};

	typedef enum logic [2:0] {
		PLANE_LEFT   = 3'd0, // r3 + r0
		PLANE_RIGHT  = 3'd1, // r3 - r0
		PLANE_BOTTOM = 3'd2, // r3 + r1
		PLANE_TOP    = 3'd3, // r3 - r1
		PLANE_NEAR   = 3'd4, // r2
		PLANE_FAR    = 3'd5  // r3 - r2
	} plane_e;

	typedef enum logic [1:0] {
		ALPHA_OPAQUE  = 2'd0,
		ALPHA_MASKED  = 2'd1,
		ALPHA_BLENDED = 2'd2,
		ALPHA_NONE    = 2'd3
	} alpha_e;

	typedef enum logic [1:0] {
		LIST_NONE        = 2'd0,
		LIST_OPAQUE      = 2'd1,
		LIST_MASKED      = 2'd2,
		LIST_TRANSPARENT = 2'd3
	} list_e;

	// One draw section as it travels down the cell chain
	typedef struct packed {
		logic                          frame_start;
		logic                          cull;
		logic                          drawable;
		logic                          casts_shadow;
		alpha_e                        alpha_mode;
		logic                          box_valid;
		logic [AXES-1:0][COORD_W-1:0]  bmin;
		logic [AXES-1:0][COORD_W-1:0]  bmax;
		logic                          outside;
	} item_t;

	// Matrix element (row r, column k), sign-extended to coefficient width
	function automatic logic [COEF_W-1:0] mat_elem(input mat_t m, input int r, input int k);
		logic [COORD_W-1:0] w;
		w = m[3'(2 * r + (k >> 1))][(k & 1) * COORD_W +: COORD_W];
		return {w[COORD_W-1], w};
	endfunction

	// Form one frustum plane from the matrix rows; sums are exact at 33 bits
	function automatic plane_t plane_coef(input mat_t m, input plane_e p);
		plane_t             pl;
		int                 rb;
		logic               sub;
		logic               only_b;
		logic [COEF_W-1:0]  a;
		logic [COEF_W-1:0]  b;
		rb     = 0;
		sub    = 1'b0;
		only_b = 1'b0;
		unique case (p)
			PLANE_LEFT:   begin rb = 0; sub = 1'b0; end
			PLANE_RIGHT:  begin rb = 0; sub = 1'b1; end
			PLANE_BOTTOM: begin rb = 1; sub = 1'b0; end
			PLANE_TOP:    begin rb = 1; sub = 1'b1; end
			PLANE_NEAR:   begin rb = 2; only_b = 1'b1; end
			PLANE_FAR:    begin rb = 2; sub = 1'b1; end
			default:      begin rb = 0; sub = 1'b0; end
		endcase
		for (int k = 0; k <= W_IDX; k++) begin
			a = mat_elem(m, 3, k);
			b = mat_elem(m, rb, k);
			if (only_b)
				pl[k] = b;
			else if (sub)
				pl[k] = a - b;
			else
				pl[k] = a + b;
		end
		return pl;
	endfunction

endpackage

// File: src/dfcc_cell.sv
// One plane-test cell of the cull chain: picks the positive vertex, multiplies, sums.
// Depends on dfcc_pkg for item_t, plane_t and the arithmetic widths.

module dfcc_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  dfcc_pkg::plane_t   plane,
	input  logic               up_valid,
	input  dfcc_pkg::item_t    up_item,
	output logic               up_hold,
	output logic               dn_valid,
	output dfcc_pkg::item_t    dn_item,
	input  logic               dn_hold
);

	logic                                   valid_s1;
	logic                                   valid_s2;
	dfcc_pkg::item_t                        item_s1;
	dfcc_pkg::item_t                        item_s2;
	dfcc_pkg::item_t                        item_d2;
	logic signed [dfcc_pkg::PROD_W-1:0]     prod_s1 [dfcc_pkg::AXES];
	logic signed [dfcc_pkg::PROD_W-1:0]     prod_d  [dfcc_pkg::AXES];
	logic signed [dfcc_pkg::PROD_W-1:0]     coef_ext [dfcc_pkg::AXES];
	logic signed [dfcc_pkg::PROD_W-1:0]     vert_ext [dfcc_pkg::AXES];
	logic signed [dfcc_pkg::SUM_W-1:0]      dot_sum;
	logic signed [dfcc_pkg::SUM_W-1:0]      w_term;
	logic                                   hold_s1;
	logic                                   hold_s2;

	// Stall chain: a stage holds only if it is full and its successor holds
	assign hold_s2 = valid_s2 & dn_hold;
	assign hold_s1 = valid_s1 & hold_s2;
	assign up_hold = hold_s1;

	// Pick the positive vertex per axis and form the exact products
	always_comb begin
		for (int k = 0; k < dfcc_pkg::AXES; k++) begin
			coef_ext[k] = dfcc_pkg::PROD_W'($signed(plane[k]));
			if (plane[k][dfcc_pkg::COEF_W-1])
				vert_ext[k] = dfcc_pkg::PROD_W'($signed(up_item.bmin[k]));
			else
				vert_ext[k] = dfcc_pkg::PROD_W'($signed(up_item.bmax[k]));
			prod_d[k] = coef_ext[k] * vert_ext[k];
		end
	end

	// Add the products and the offset scaled by 2^16; the sign decides
	assign w_term  = dfcc_pkg::SUM_W'($signed({plane[dfcc_pkg::W_IDX],
		{dfcc_pkg::FRAC_W{1'b0}}}));
	assign dot_sum = dfcc_pkg::SUM_W'(prod_s1[0]) + dfcc_pkg::SUM_W'(prod_s1[1])
		+ dfcc_pkg::SUM_W'(prod_s1[2]) + w_term;

	// Fold this plane's verdict into the section
	always_comb begin
		item_d2         = item_s1;
		item_d2.outside = item_s1.outside | dot_sum[dfcc_pkg::SUM_W-1];
	end

	// Advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!hold_s1)
				valid_s1 <= up_valid;
			if (!hold_s2)
				valid_s2 <= valid_s1;
		end
	end

	// Capture payloads on transfer into each stage
	always_ff @(posedge clk) begin
		if (!hold_s1 && up_valid) begin
			item_s1 <= up_item;
			for (int k = 0; k < dfcc_pkg::AXES; k++)
				prod_s1[k] <= prod_d[k];
		end
		if (!hold_s2 && valid_s1)
			item_s2 <= item_d2;
	end

	assign dn_valid = valid_s2;
	assign dn_item  = item_s2;

	a_empty_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !up_hold)
		else $error("empty first stage stalls upstream");

	a_outside_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !hold_s2 && item_s1.outside) |=> item_s2.outside)
		else $error("outside flag lost between stages");

	a_held_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && hold_s2) |=> valid_s1)
		else $error("blocked stage dropped its item");

endmodule

// File: src/dfcc_tally.sv
// List routing, saturating per-frame counters and the output register.
// Depends on dfcc_pkg for item_t and the list and alpha codes.

module dfcc_tally #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              up_valid,
	input  dfcc_pkg::item_t                   up_item,
	output logic                              up_hold,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              to_shadow,
	output logic [1:0]                        main_list,
	output logic                              was_culled,
	output logic [dfcc_pkg::OUT_CNT_W-1:0]    opaque_count,
	output logic [dfcc_pkg::OUT_CNT_W-1:0]    masked_count,
	output logic [dfcc_pkg::OUT_CNT_W-1:0]    transparent_count,
	output logic [dfcc_pkg::OUT_CNT_W-1:0]    shadow_count,
	output logic [dfcc_pkg::OUT_CNT_W-1:0]    culled_count
);

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	logic                      valid_q;
	logic                      to_shadow_q;
	dfcc_pkg::list_e           list_q;
	logic                      culled_q;
	logic [COUNT_WIDTH-1:0]    opaque_q;
	logic [COUNT_WIDTH-1:0]    masked_q;
	logic [COUNT_WIDTH-1:0]    transparent_q;
	logic [COUNT_WIDTH-1:0]    shadow_q;
	logic [COUNT_WIDTH-1:0]    culled_cnt_q;
	logic                      capture;
	logic                      culled;
	logic                      inc_shadow;
	logic                      inc_opaque;
	logic                      inc_masked;
	logic                      inc_transparent;
	dfcc_pkg::list_e           list_d;

	assign up_hold = valid_q & out_stall;
	assign capture = up_valid & ~up_hold;

	// Route the section to its lists
	always_comb begin
		culled          = up_item.drawable & up_item.cull & up_item.box_valid & up_item.outside;
		inc_shadow      = up_item.drawable & up_item.casts_shadow;
		inc_opaque      = 1'b0;
		inc_masked      = 1'b0;
		inc_transparent = 1'b0;
		list_d          = dfcc_pkg::LIST_NONE;
		if (up_item.drawable && !culled) begin
			unique case (up_item.alpha_mode)
				dfcc_pkg::ALPHA_OPAQUE:  begin
					list_d     = dfcc_pkg::LIST_OPAQUE;
					inc_opaque = 1'b1;
				end
				dfcc_pkg::ALPHA_MASKED:  begin
					list_d     = dfcc_pkg::LIST_MASKED;
					inc_masked = 1'b1;
				end
				dfcc_pkg::ALPHA_BLENDED: begin
					list_d          = dfcc_pkg::LIST_TRANSPARENT;
					inc_transparent = 1'b1;
				end
				dfcc_pkg::ALPHA_NONE:    list_d = dfcc_pkg::LIST_NONE;
				default:                 list_d = dfcc_pkg::LIST_NONE;
			endcase
		end
	end

	// Clear on frame start, then bump and saturate
	function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] cur,
		input logic clr, input logic inc);
		logic [COUNT_WIDTH-1:0] base;
		base = clr ? '0 : cur;
		return (inc && base != CNT_MAX) ? base + COUNT_WIDTH'(1) : base;
	endfunction

	// Hold the output until transfer; update totals on capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= 1'b0;
			opaque_q      <= '0;
			masked_q      <= '0;
			transparent_q <= '0;
			shadow_q      <= '0;
			culled_cnt_q  <= '0;
		end else begin
			if (!up_hold)
				valid_q <= up_valid;
			if (capture) begin
				opaque_q      <= bump(opaque_q, up_item.frame_start, inc_opaque);
				masked_q      <= bump(masked_q, up_item.frame_start, inc_masked);
				transparent_q <= bump(transparent_q, up_item.frame_start, inc_transparent);
				shadow_q      <= bump(shadow_q, up_item.frame_start, inc_shadow);
				culled_cnt_q  <= bump(culled_cnt_q, up_item.frame_start, culled);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			to_shadow_q <= inc_shadow;
			list_q      <= list_d;
			culled_q    <= culled;
		end
	end

	assign out_valid         = valid_q;
	assign to_shadow         = to_shadow_q;
	assign main_list         = list_q;
	assign was_culled        = culled_q;
	assign opaque_count      = dfcc_pkg::OUT_CNT_W'(opaque_q);
	assign masked_count      = dfcc_pkg::OUT_CNT_W'(masked_q);
	assign transparent_count = dfcc_pkg::OUT_CNT_W'(transparent_q);
	assign shadow_count      = dfcc_pkg::OUT_CNT_W'(shadow_q);
	assign culled_count      = dfcc_pkg::OUT_CNT_W'(culled_cnt_q);

	a_one_main_list: assert property (@(posedge clk) disable iff (!arst_n)
		capture |-> $countones({inc_opaque, inc_masked, inc_transparent, culled}) <= 1)
		else $error("section counted in more than one main list");

	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(capture && up_item.frame_start) |=> (opaque_q <= COUNT_WIDTH'(1))
		&& (masked_q <= COUNT_WIDTH'(1)) && (transparent_q <= COUNT_WIDTH'(1))
		&& (shadow_q <= COUNT_WIDTH'(1)) && (culled_cnt_q <= COUNT_WIDTH'(1)))
		else $error("counters not cleared on frame start");

	a_culled_no_list: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && culled_q) |-> (list_q == dfcc_pkg::LIST_NONE))
		else $error("culled section placed in a main list");

	a_counts_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && out_stall) |=> $stable(opaque_q) && $stable(culled_cnt_q)
		&& $stable(shadow_q))
		else $error("counters moved while result waits");

endmodule

// File: src/draw_frustum_cull_classifier_core.sv
// Pipeline: a section passes two stages per plane cell over six cells, then the output
// register. Throughput: one section per cycle while out_stall does not hold the chain.
// Each plane cell holds one 33x32 multiply stage and one 68-bit sum stage.
// Reset: matrix returns to identity, plane registers to its planes, counters and valids clear.
// Top level: configuration registers, plane registers, six-cell chain and tally stage.
// Depends on dfcc_pkg, dfcc_cell and dfcc_tally.

module draw_frustum_cull_classifier_core #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [dfcc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dfcc_pkg::CFG_DATA_W-1:0]    cfg_data,
	// section input
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               frame_start,
	input  logic                               cull,
	input  logic                               drawable,
	input  logic                               casts_shadow,
	input  logic [1:0]                         alpha_mode,
	input  logic                               box_valid,
	input  logic signed [31:0]                 min_x,
	input  logic signed [31:0]                 min_y,
	input  logic signed [31:0]                 min_z,
	input  logic signed [31:0]                 max_x,
	input  logic signed [31:0]                 max_y,
	input  logic signed [31:0]                 max_z,
	// result output
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               to_shadow,
	output logic [1:0]                         main_list,
	output logic                               was_culled,
	output logic [15:0]                        opaque_count,
	output logic [15:0]                        masked_count,
	output logic [15:0]                        transparent_count,
	output logic [15:0]                        shadow_count,
	output logic [15:0]                        culled_count
);

	localparam int NP = dfcc_pkg::NUM_PLANES;

	dfcc_pkg::mat_t     mat_q;
	dfcc_pkg::mat_t     mat_d;
	logic               cfg_we;
	dfcc_pkg::plane_t   plane_q [NP];
	dfcc_pkg::item_t    in_item;
	dfcc_pkg::item_t    link_item  [NP+1];
	logic               link_valid [NP+1];
	logic               link_hold  [NP+1];

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;

	// Next matrix contents including a write in this cycle
	always_comb begin
		mat_d = mat_q;
		for (int i = 0; i < dfcc_pkg::MAT_REGS; i++) begin
			if (cfg_we && cfg_index == dfcc_pkg::CFG_IDX_W'(i))
				mat_d[i] = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mat_q <= dfcc_pkg::MAT_RESET;
		else if (cfg_we)
			mat_q <= mat_d;
	end

	// Refresh plane coefficients together with the matrix write
	for (genvar p = 0; p < NP; p++) begin : g_plane
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				plane_q[p] <= dfcc_pkg::plane_coef(dfcc_pkg::MAT_RESET, dfcc_pkg::plane_e'(p));
			else if (cfg_we)
				plane_q[p] <= dfcc_pkg::plane_coef(mat_d, dfcc_pkg::plane_e'(p));
		end
	end

	// Pack the incoming section
	always_comb begin
		in_item.frame_start  = frame_start;
		in_item.cull         = cull;
		in_item.drawable     = drawable;
		in_item.casts_shadow = casts_shadow;
		in_item.alpha_mode   = dfcc_pkg::alpha_e'(alpha_mode);
		in_item.box_valid    = box_valid;
		in_item.bmin         = {min_z, min_y, min_x};
		in_item.bmax         = {max_z, max_y, max_x};
		in_item.outside      = 1'b0;
	end

	assign link_item[0]  = in_item;
	assign link_valid[0] = in_valid;
	assign in_stall      = link_hold[0];

	// Chain of plane cells, one per frustum plane
	for (genvar p = 0; p < NP; p++) begin : g_cell
		dfcc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.plane    (plane_q[p]),
			.up_valid (link_valid[p]),
			.up_item  (link_item[p]),
			.up_hold  (link_hold[p]),
			.dn_valid (link_valid[p+1]),
			.dn_item  (link_item[p+1]),
			.dn_hold  (link_hold[p+1])
		);
	end

	dfcc_tally #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_tally (
		.clk               (clk),
		.arst_n            (arst_n),
		.up_valid          (link_valid[NP]),
		.up_item           (link_item[NP]),
		.up_hold           (link_hold[NP]),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.to_shadow         (to_shadow),
		.main_list         (main_list),
		.was_culled        (was_culled),
		.opaque_count      (opaque_count),
		.masked_count      (masked_count),
		.transparent_count (transparent_count),
		.shadow_count      (shadow_count),
		.culled_count      (culled_count)
	);

endmodule

// File: tb/sv/draw_frustum_cull_classifier_core_test.sv
// Self-checking bench for draw_frustum_cull_classifier_core: predicts each section's lists
// and running counts from its own copy of the matrix and compares every result transfer.
// Depends on dfcc_pkg and the core RTL only.
`timescale 1ns / 1ps

module draw_frustum_cull_classifier_core_test;

	localparam int Q_ONE        = 1 << dfcc_pkg::FRAC_W;
	localparam int Q_HALF       = Q_ONE / 2;
	localparam int IDLE_PCT     = 21;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 40000;
	localparam int PRINT_CAP    = 40;

	typedef enum int {
		SET_IDENTITY,
		SET_SMALL,
		SET_WILD,
		SET_LOW,
		SET_HIGH,
		SET_ZERO
	} setting_e;

	typedef struct packed {
		logic                                             frame_start;
		logic                                             cull;
		logic                                             drawable;
		logic                                             casts_shadow;
		dfcc_pkg::alpha_e                                 alpha_mode;
		logic                                             box_valid;
		logic [dfcc_pkg::AXES-1:0][dfcc_pkg::COORD_W-1:0] lo_c;
		logic [dfcc_pkg::AXES-1:0][dfcc_pkg::COORD_W-1:0] hi_c;
	} section_t;

	typedef struct packed {
		logic                           to_shadow;
		dfcc_pkg::list_e                main_list;
		logic                           was_culled;
		logic [dfcc_pkg::OUT_CNT_W-1:0] opaque;
		logic [dfcc_pkg::OUT_CNT_W-1:0] masked;
		logic [dfcc_pkg::OUT_CNT_W-1:0] transparent;
		logic [dfcc_pkg::OUT_CNT_W-1:0] shadow;
		logic [dfcc_pkg::OUT_CNT_W-1:0] culled;
	} result_t;

	// Predicts section results and holds them until the matching transfer comes out
	class cull_scoreboard;
		logic [dfcc_pkg::CFG_DATA_W-1:0] mat [dfcc_pkg::MAT_REGS];
		logic [dfcc_pkg::OUT_CNT_W-1:0]  n_opaque, n_masked, n_transparent, n_shadow, n_culled;
		result_t                         expected_q [$];
		int                              errors, checked, culled_seen;

		function new();
			for (int i = 0; i < dfcc_pkg::MAT_REGS; i++)
				mat[i] = dfcc_pkg::MAT_RESET[i];
			n_opaque      = '0;
			n_masked      = '0;
			n_transparent = '0;
			n_shadow      = '0;
			n_culled      = '0;
			errors        = 0;
			checked       = 0;
			culled_seen   = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Ignore indexes past the matrix
		function void set_register(logic [dfcc_pkg::CFG_IDX_W-1:0] idx,
				logic [dfcc_pkg::CFG_DATA_W-1:0] data);
			if (idx < dfcc_pkg::MAT_REGS)
				mat[idx] = data;
		endfunction

		function logic signed [dfcc_pkg::COEF_W-1:0] element(int r, int k);
			logic [dfcc_pkg::COORD_W-1:0] w;
			w = mat[2 * r + k / 2][(k % 2) * dfcc_pkg::COORD_W +: dfcc_pkg::COORD_W];
			return {w[dfcc_pkg::COORD_W-1], w};
		endfunction

		// Row sums at 33 bits are exact
		function logic signed [dfcc_pkg::COEF_W-1:0] plane_coef(dfcc_pkg::plane_e p, int k);
			logic signed [dfcc_pkg::COEF_W-1:0] w_row;
			w_row = element(3, k);
			case (p)
				dfcc_pkg::PLANE_LEFT:   return w_row + element(0, k);
				dfcc_pkg::PLANE_RIGHT:  return w_row - element(0, k);
				dfcc_pkg::PLANE_BOTTOM: return w_row + element(1, k);
				dfcc_pkg::PLANE_TOP:    return w_row - element(1, k);
				dfcc_pkg::PLANE_NEAR:   return element(2, k);
				default:                return w_row - element(2, k);
			endcase
		endfunction

		// Positive-vertex test against every plane; any negative distance culls
		function bit beyond_frustum(section_t s);
			logic signed [dfcc_pkg::COEF_W-1:0]  c;
			logic signed [dfcc_pkg::COORD_W-1:0] v;
			logic signed [dfcc_pkg::SUM_W+3:0]   acc;
			logic signed [dfcc_pkg::SUM_W+3:0]   ofs;
			for (int p = 0; p < dfcc_pkg::NUM_PLANES; p++) begin
				acc = '0;
				for (int k = 0; k < dfcc_pkg::AXES; k++) begin
					c = plane_coef(dfcc_pkg::plane_e'(p), k);
					v = (c >= 0) ? s.hi_c[k] : s.lo_c[k];
					acc = acc + c * v;
				end
				ofs = plane_coef(dfcc_pkg::plane_e'(p), dfcc_pkg::W_IDX);
				acc = acc + (ofs <<< dfcc_pkg::FRAC_W);
				if (acc < 0)
					return 1'b1;
			end
			return 1'b0;
		endfunction

		function logic [dfcc_pkg::OUT_CNT_W-1:0] bump(logic [dfcc_pkg::OUT_CNT_W-1:0] v);
			return (v == {dfcc_pkg::OUT_CNT_W{1'b1}}) ? v : v + 1'b1;
		endfunction

		// Route one accepted section and advance the frame counts
		function void note_section(section_t s);
			result_t r;
			r = '0;
			if (s.frame_start) begin
				n_opaque      = '0;
				n_masked      = '0;
				n_transparent = '0;
				n_shadow      = '0;
				n_culled      = '0;
			end
			if (s.drawable) begin
				if (s.casts_shadow) begin
					r.to_shadow = 1'b1;
					n_shadow    = bump(n_shadow);
				end
				if (s.cull && s.box_valid && beyond_frustum(s)) begin
					r.was_culled = 1'b1;
					n_culled     = bump(n_culled);
				end else begin
					case (s.alpha_mode)
						dfcc_pkg::ALPHA_OPAQUE: begin
							r.main_list = dfcc_pkg::LIST_OPAQUE;
							n_opaque    = bump(n_opaque);
						end
						dfcc_pkg::ALPHA_MASKED: begin
							r.main_list = dfcc_pkg::LIST_MASKED;
							n_masked    = bump(n_masked);
						end
						dfcc_pkg::ALPHA_BLENDED: begin
							r.main_list   = dfcc_pkg::LIST_TRANSPARENT;
							n_transparent = bump(n_transparent);
						end
						default: ;
					endcase
				end
			end
			r.opaque      = n_opaque;
			r.masked      = n_masked;
			r.transparent = n_transparent;
			r.shadow      = n_shadow;
			r.culled      = n_culled;
			expected_q.insert(expected_q.size(), r);
		endfunction

		task report(string msg);
			if (errors < PRINT_CAP)
				$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task match(string field, int got, int want);
			if (got != want)
				report($sformatf("result %0d %s got %0d expected %0d", checked, field, got, want));
		endtask

		task check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				report("result transfer with no section outstanding");
				return;
			end
			want = expected_q.pop_front();
			match("to_shadow", got.to_shadow, want.to_shadow);
			match("main_list", int'(got.main_list), int'(want.main_list));
			match("was_culled", got.was_culled, want.was_culled);
			match("opaque_count", got.opaque, want.opaque);
			match("masked_count", got.masked, want.masked);
			match("transparent_count", got.transparent, want.transparent);
			match("shadow_count", got.shadow, want.shadow);
			match("culled_count", got.culled, want.culled);
			if (want.was_culled)
				culled_seen++;
			checked++;
		endtask
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [dfcc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [dfcc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	logic                            frame_start = 1'b0;
	logic                            cull = 1'b0;
	logic                            drawable = 1'b0;
	logic                            casts_shadow = 1'b0;
	logic [1:0]                      alpha_mode = '0;
	logic                            box_valid = 1'b0;
	logic signed [31:0]              min_x = '0;
	logic signed [31:0]              min_y = '0;
	logic signed [31:0]              min_z = '0;
	logic signed [31:0]              max_x = '0;
	logic signed [31:0]              max_y = '0;
	logic signed [31:0]              max_z = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic                            to_shadow;
	logic [1:0]                      main_list;
	logic                            was_culled;
	logic [15:0]                     opaque_count;
	logic [15:0]                     masked_count;
	logic [15:0]                     transparent_count;
	logic [15:0]                     shadow_count;
	logic [15:0]                     culled_count;

	bit             calm = 1'b0;
	int             settings = 1;
	cull_scoreboard sb;

	draw_frustum_cull_classifier_core dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Stall the result side at random unless in a calm stretch
	always @(posedge clk)
		out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);

	// Watch every transfer on the three channels
	always @(posedge clk) begin : monitor
		section_t sec;
		result_t  got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.set_register(cfg_index, cfg_data);
			if (in_valid && !in_stall) begin
				sec.frame_start  = frame_start;
				sec.cull         = cull;
				sec.drawable     = drawable;
				sec.casts_shadow = casts_shadow;
				sec.alpha_mode   = dfcc_pkg::alpha_e'(alpha_mode);
				sec.box_valid    = box_valid;
				sec.lo_c         = {min_z, min_y, min_x};
				sec.hi_c         = {max_z, max_y, max_x};
				sb.note_section(sec);
			end
			if (out_valid && !out_stall) begin
				got.to_shadow   = to_shadow;
				got.main_list   = dfcc_pkg::list_e'(main_list);
				got.was_culled  = was_culled;
				got.opaque      = opaque_count;
				got.masked      = masked_count;
				got.transparent = transparent_count;
				got.shadow      = shadow_count;
				got.culled      = culled_count;
				sb.check_result(got);
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
		$display("FAIL draw_frustum_cull_classifier_core");
		$finish;
	end

	function automatic int near_coord(int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	function automatic logic [dfcc_pkg::COORD_W-1:0] extreme_coord();
		case ($urandom_range(3))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return '0;
			default: return $urandom;
		endcase
	endfunction

	function automatic section_t section_of(bit fs, bit cl, bit dr, bit sh,
			dfcc_pkg::alpha_e am, bit bv, int lx, int ly, int lz, int hx, int hy, int hz);
		section_t s;
		s.frame_start  = fs;
		s.cull         = cl;
		s.drawable     = dr;
		s.casts_shadow = sh;
		s.alpha_mode   = am;
		s.box_valid    = bv;
		s.lo_c         = {lz, ly, lx};
		s.hi_c         = {hz, hy, hx};
		return s;
	endfunction

	// Mostly well-formed boxes near the origin; the rest inverted, raw or extreme
	function automatic section_t random_section();
		section_t s;
		int       kind, c, h;
		s.frame_start  = ($urandom_range(99) < 3);
		s.cull         = ($urandom_range(99) < 80);
		s.drawable     = ($urandom_range(99) < 85);
		s.casts_shadow = $urandom_range(1);
		s.alpha_mode   = dfcc_pkg::alpha_e'($urandom_range(3));
		s.box_valid    = ($urandom_range(99) < 85);
		kind = $urandom_range(99);
		for (int k = 0; k < dfcc_pkg::AXES; k++) begin
			c = near_coord(3 * Q_ONE);
			h = $urandom_range(2 * Q_ONE);
			if (kind < 60) begin
				s.lo_c[k] = c - h;
				s.hi_c[k] = c + h;
			end else if (kind < 70) begin
				s.lo_c[k] = c + h + 1;
				s.hi_c[k] = c - h;
			end else if (kind < 85) begin
				s.lo_c[k] = $urandom;
				s.hi_c[k] = $urandom;
			end else begin
				s.lo_c[k] = extreme_coord();
				s.hi_c[k] = extreme_coord();
			end
		end
		return s;
	endfunction

	// Offer one section, idling first at random, and hold it until the transfer
	task automatic send_section(input section_t s);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		frame_start  <= s.frame_start;
		cull         <= s.cull;
		drawable     <= s.drawable;
		casts_shadow <= s.casts_shadow;
		alpha_mode   <= s.alpha_mode;
		box_valid    <= s.box_valid;
		min_x        <= s.lo_c[0];
		min_y        <= s.lo_c[1];
		min_z        <= s.lo_c[2];
		max_x        <= s.hi_c[0];
		max_y        <= s.hi_c[1];
		max_z        <= s.hi_c[2];
		in_valid     <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Hold the sender until every result is back, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all matrix registers, optionally followed by a write to an unused index
	task automatic load_matrix(input setting_e kind, input bit junk);
		logic [dfcc_pkg::CFG_DATA_W-1:0] m [dfcc_pkg::MAT_REGS];
		for (int i = 0; i < dfcc_pkg::MAT_REGS; i++) begin
			case (kind)
				SET_IDENTITY: m[i] = dfcc_pkg::MAT_RESET[i];
				SET_SMALL:    m[i] = {near_coord(2 * Q_ONE), near_coord(2 * Q_ONE)};
				SET_WILD:     m[i] = {$urandom, $urandom};
				SET_LOW:      m[i] = {2{32'h8000_0000}};
				SET_HIGH:     m[i] = {2{32'h7FFF_FFFF}};
				default:      m[i] = '0;
			endcase
		end
		for (int i = 0; i < dfcc_pkg::MAT_REGS + junk; i++) begin
			cfg_index <= (i < dfcc_pkg::MAT_REGS) ? dfcc_pkg::CFG_IDX_W'(i)
				: dfcc_pkg::CFG_IDX_W'($urandom_range(dfcc_pkg::MAT_REGS,
				(1 << dfcc_pkg::CFG_IDX_W) - 1));
			cfg_data  <= (i < dfcc_pkg::MAT_REGS) ? m[i] : {$urandom, $urandom};
			cfg_valid <= 1'b1;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
		settings++;
	endtask

	task automatic run_phase(input setting_e kind, input int n, input bit quiet, input bit junk);
		settle();
		load_matrix(kind, junk);
		calm = quiet;
		repeat (n) send_section(random_section());
		calm = 1'b0;
	endtask

	initial begin
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sections against the reset matrix (identity)
		send_section(section_of(1, 0, 0, 1, dfcc_pkg::ALPHA_OPAQUE, 1, -Q_HALF, -Q_HALF, 0,
			Q_HALF, Q_HALF, Q_HALF));
		send_section(section_of(0, 0, 1, 1, dfcc_pkg::ALPHA_OPAQUE, 1, 0, 0, 0, 0, 0, 0));
		send_section(section_of(0, 0, 1, 0, dfcc_pkg::ALPHA_MASKED, 1, 0, 0, 0, 0, 0, 0));
		send_section(section_of(0, 0, 1, 1, dfcc_pkg::ALPHA_BLENDED, 1, 0, 0, 0, 0, 0, 0));
		send_section(section_of(0, 0, 1, 0, dfcc_pkg::ALPHA_NONE, 1, 0, 0, 0, 0, 0, 0));
		send_section(section_of(0, 1, 1, 0, dfcc_pkg::ALPHA_OPAQUE, 1, -Q_HALF, -Q_HALF, 0,
			Q_HALF, Q_HALF, Q_HALF));
		// one box beyond each plane
		send_section(section_of(0, 1, 1, 1, dfcc_pkg::ALPHA_OPAQUE, 1, -3 * Q_ONE, 0, 0,
			-2 * Q_ONE, 0, Q_HALF));
		send_section(section_of(0, 1, 1, 0, dfcc_pkg::ALPHA_MASKED, 1, 2 * Q_ONE, 0, 0,
			3 * Q_ONE, 0, Q_HALF));
		send_section(section_of(0, 1, 1, 1, dfcc_pkg::ALPHA_BLENDED, 1, 0, -3 * Q_ONE, 0,
			0, -2 * Q_ONE, Q_HALF));
		send_section(section_of(0, 1, 1, 0, dfcc_pkg::ALPHA_NONE, 1, 0, 2 * Q_ONE, 0,
			0, 3 * Q_ONE, Q_HALF));
		send_section(section_of(0, 1, 1, 1, dfcc_pkg::ALPHA_OPAQUE, 1, 0, 0, -3 * Q_ONE,
			0, 0, -2 * Q_ONE));
		send_section(section_of(0, 1, 1, 0, dfcc_pkg::ALPHA_MASKED, 1, 0, 0, 2 * Q_ONE,
			0, 0, 3 * Q_ONE));
		// invalid box and culling off both keep an outside box
		send_section(section_of(0, 1, 1, 1, dfcc_pkg::ALPHA_OPAQUE, 0, 2 * Q_ONE, 0, 0,
			3 * Q_ONE, 0, Q_HALF));
		send_section(section_of(0, 0, 1, 0, dfcc_pkg::ALPHA_BLENDED, 1, 2 * Q_ONE, 0, 0,
			3 * Q_ONE, 0, Q_HALF));
		// inverted boxes, one outside and one inside
		send_section(section_of(0, 1, 1, 1, dfcc_pkg::ALPHA_MASKED, 1, 2 * Q_ONE, 0, 0,
			-2 * Q_ONE, 0, Q_HALF));
		send_section(section_of(0, 1, 1, 0, dfcc_pkg::ALPHA_OPAQUE, 1, Q_HALF, Q_HALF, Q_HALF,
			-Q_HALF, -Q_HALF, 0));
		// coordinate extremes
		send_section(section_of(0, 1, 1, 1, dfcc_pkg::ALPHA_BLENDED, 1, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_section(section_of(1, 1, 1, 1, dfcc_pkg::ALPHA_NONE, 1, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_section(section_of(0, 1, 1, 0, dfcc_pkg::ALPHA_OPAQUE, 1, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		send_section(section_of(1, 0, 1, 1, dfcc_pkg::ALPHA_MASKED, 0, 0, 0, 0, 0, 0, 0));
		// touching the right plane stays; one step past culls
		send_section(section_of(0, 1, 1, 0, dfcc_pkg::ALPHA_OPAQUE, 1, Q_ONE, 0, 0,
			Q_ONE, 0, 0));
		send_section(section_of(0, 1, 1, 0, dfcc_pkg::ALPHA_OPAQUE, 1, Q_ONE + 1, 0, 0,
			Q_ONE + 1, 0, 0));

		// Random sections across matrix settings, extremes included
		run_phase(SET_SMALL, 300, 1'b0, 1'b0);
		run_phase(SET_WILD, 150, 1'b0, 1'b1);
		run_phase(SET_LOW, 150, 1'b0, 1'b0);
		run_phase(SET_HIGH, 150, 1'b0, 1'b1);
		run_phase(SET_ZERO, 100, 1'b0, 1'b0);
		run_phase(SET_SMALL, 300, 1'b0, 1'b0);
		run_phase(SET_SMALL, 300, 1'b1, 1'b0);
		run_phase(SET_IDENTITY, 250, 1'b0, 1'b1);

		settle();

		$display("checked %0d sections under %0d matrix settings, %0d of them culled;",
			sb.checked, settings, sb.culled_seen);
		$display("plane edges, inverted and extreme boxes, frame clears and random stalls ran");
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS draw_frustum_cull_classifier_core");
		else
			$display("FAIL draw_frustum_cull_classifier_core");
		$finish;
	end

endmodule
